@@ hdl/wzs_pkg.sv @@
// Package for the sliding-window z-score size outlier core.
// Holds shared constants, register and event codes, and the sequencer state type.
// No dependencies.
`default_nettype none
package wzs_pkg;

    localparam int unsigned WINDOW_DEPTH_DEF = 1024;
    localparam int unsigned SIZE_BITS_DEF    = 24;
    localparam int unsigned MIN_SAMPLES_DEF  = 20;

    localparam int unsigned LEN_W  = 11;
    localparam int unsigned THR_W  = 16;
    localparam int unsigned CODE_W = 2;
    localparam int unsigned ADDR_W = 4;

    localparam logic [LEN_W-1:0] WLEN_RESET = 11'd1024;
    localparam logic [THR_W-1:0] THR_RESET  = 16'd768;

    localparam logic [1:0] REG_WLEN    = 2'd0;
    localparam logic [1:0] REG_IN_THR  = 2'd1;
    localparam logic [1:0] REG_OUT_THR = 2'd2;

    localparam logic [CODE_W-1:0] EV_NONE = 2'd0;
    localparam logic [CODE_W-1:0] EV_IN   = 2'd1;
    localparam logic [CODE_W-1:0] EV_OUT  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_MOX,
        S_MOY,
        S_MX,
        S_MY,
        S_NQ,
        S_S2,
        S_NX,
        S_D2,
        S_T2,
        S_TV,
        S_OUT
    } state_t;

endpackage
`default_nettype wire

@@ hdl/wzs_hist_mem.sv @@
// Sample history memory: one write port and one read port with registered read data.
// Holds the input and output size of each window slot side by side. No dependencies.
`default_nettype none
module wzs_hist_mem #(
    parameter int unsigned AW = 10,
    parameter int unsigned DW = 48
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(1<<AW)-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ hdl/wzs_mul.sv @@
// Shift-and-add multiplier that retires one multiplier bit per cycle.
// Stops as soon as the remaining multiplier bits are zero. No dependencies.
`default_nettype none
module wzs_mul #(
    parameter int unsigned PW = 102,
    parameter int unsigned MB = 35
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [PW-1:0] a_in,
    input  wire logic [MB-1:0] b_in,
    output logic               done,
    output logic      [PW-1:0] result
);

    logic          busy_reg;
    logic          done_reg;
    logic [PW-1:0] acc_reg;
    logic [PW-1:0] a_reg;
    logic [MB-1:0] b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && b_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            a_reg   <= a_in;
            b_reg   <= b_in;
        end else if (busy_reg && b_reg != '0) begin
            if (b_reg[0]) begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule
`default_nettype wire

@@ hdl/window_zscore_size_outlier_core.sv @@
// Sliding-window z-score outlier core: history memory, sequencer, shared multiplier.
// Uses wzs_pkg, wzs_hist_mem and wzs_mul.
// One transaction is handled at a time: s_ready is high only while the sequencer is
// idle, and every multiply shares the single bit-serial multiplier.
// Reset clears counts, sums and registers; history entries are valid only once written.
`default_nettype none
module window_zscore_size_outlier_core #(
    parameter int unsigned WINDOW_DEPTH = wzs_pkg::WINDOW_DEPTH_DEF,
    parameter int unsigned SIZE_BITS    = wzs_pkg::SIZE_BITS_DEF,
    parameter int unsigned MIN_SAMPLES  = wzs_pkg::MIN_SAMPLES_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [wzs_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [SIZE_BITS-1:0]        s_in_size,
    input  wire logic [SIZE_BITS-1:0]        s_out_size,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic      [wzs_pkg::CODE_W-1:0]  m_event_code,
    output logic      [wzs_pkg::LEN_W-1:0]   m_samples_held
);
    import wzs_pkg::*;

    localparam int unsigned SB    = SIZE_BITS;
    localparam int unsigned AW    = $clog2(WINDOW_DEPTH);
    localparam int unsigned CMP_W = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
    localparam int unsigned SUM_W = SB + LEN_W;
    localparam int unsigned SQ_W  = 2 * SB + LEN_W;
    localparam int unsigned VW    = 2 * SB + 2 * LEN_W;
    localparam int unsigned PW    = 2 * SB + 2 * LEN_W + 32;
    localparam int unsigned MB    = (SUM_W > 32) ? SUM_W : 32;

    state_t state_reg, state_next;

    logic [LEN_W-1:0] wlen_reg;
    logic [THR_W-1:0] in_thr_reg, out_thr_reg;
    logic [AW-1:0]    slot_reg, cur_slot_reg;
    logic [LEN_W-1:0] held_reg;
    logic [SUM_W-1:0] in_sum_reg, out_sum_reg;
    logic [SQ_W-1:0]  in_sq_reg, out_sq_reg;
    logic [SB-1:0]    x_reg, y_reg, ox_reg, oy_reg;
    logic             full_reg, ch_reg, issued_reg;
    logic [VW-1:0]    var_reg;
    logic [SUM_W-1:0] d_reg;
    logic [PW-1:0]    lhs_reg;
    logic [31:0]      t2_reg;
    logic             m_valid_reg;
    logic [CODE_W-1:0] code_reg;
    logic [CODE_W-1:0] code_out_reg;
    logic [LEN_W-1:0] held_out_reg;

    logic [LEN_W-1:0] len_eff;
    logic [AW-1:0]    slot_eff;
    logic [CMP_W-1:0] slot_inc;
    logic             wr_en, cfg_wr;
    logic [1:0]       cfg_idx;
    logic             in_acc, out_free;
    logic             is_mul, mul_start, mul_done;
    logic [PW-1:0]    mul_a, mul_res;
    logic [MB-1:0]    mul_b;
    logic [2*SB-1:0]  mem_rdata;
    logic [SUM_W-1:0] cur_sum, nx;
    logic [SQ_W-1:0]  cur_sq;
    logic [SB-1:0]    cur_x;
    logic [THR_W-1:0] cur_thr;
    logic [VW-1:0]    var_next;
    logic             held_ge_min;

    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb begin
        case (cfg_idx)
            REG_WLEN:    prdata = 32'(wlen_reg);
            REG_IN_THR:  prdata = 32'(in_thr_reg);
            REG_OUT_THR: prdata = 32'(out_thr_reg);
            default:     prdata = '0;
        endcase
    end

    always_comb begin
        if (wlen_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (32'(wlen_reg) > 32'(WINDOW_DEPTH)) begin
            len_eff = LEN_W'(WINDOW_DEPTH);
        end else begin
            len_eff = wlen_reg;
        end
    end

    assign slot_eff = (CMP_W'(slot_reg) >= CMP_W'(len_eff)) ? '0 : slot_reg;
    assign slot_inc = CMP_W'(cur_slot_reg) + CMP_W'(1);

    assign s_ready  = (state_reg == S_IDLE);
    assign in_acc   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign wr_en    = (state_reg == S_READ);

    wzs_hist_mem #(
        .AW(AW),
        .DW(2 * SB)
    ) u_mem (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (cur_slot_reg),
        .wdata ({y_reg, x_reg}),
        .re    (in_acc),
        .raddr (slot_eff),
        .rdata (mem_rdata)
    );

    assign cur_sum = ch_reg ? out_sum_reg : in_sum_reg;
    assign cur_sq  = ch_reg ? out_sq_reg  : in_sq_reg;
    assign cur_x   = ch_reg ? y_reg       : x_reg;
    assign cur_thr = ch_reg ? out_thr_reg : in_thr_reg;
    assign nx      = mul_res[SUM_W-1:0];
    assign var_next = var_reg - mul_res[VW-1:0];
    assign held_ge_min = (32'(held_reg) >= 32'(MIN_SAMPLES));

    always_comb begin
        is_mul = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            S_MOX: begin
                mul_a = PW'(ox_reg);
                mul_b = MB'(ox_reg);
            end
            S_MOY: begin
                mul_a = PW'(oy_reg);
                mul_b = MB'(oy_reg);
            end
            S_MX: begin
                mul_a = PW'(x_reg);
                mul_b = MB'(x_reg);
            end
            S_MY: begin
                mul_a = PW'(y_reg);
                mul_b = MB'(y_reg);
            end
            S_NQ: begin
                mul_a = PW'(cur_sq);
                mul_b = MB'(held_reg);
            end
            S_S2: begin
                mul_a = PW'(cur_sum);
                mul_b = MB'(cur_sum);
            end
            S_NX: begin
                mul_a = PW'(cur_x);
                mul_b = MB'(held_reg);
            end
            S_D2: begin
                mul_a = PW'(d_reg);
                mul_b = MB'(d_reg);
            end
            S_T2: begin
                mul_a = PW'(cur_thr);
                mul_b = MB'(cur_thr);
            end
            S_TV: begin
                mul_a = PW'(var_reg);
                mul_b = MB'(t2_reg);
            end
            default: begin
                is_mul = 1'b0;
            end
        endcase
    end

    assign mul_start = is_mul && !issued_reg;

    wzs_mul #(
        .PW(PW),
        .MB(MB)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .done    (mul_done),
        .result  (mul_res)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = full_reg ? S_MOX : S_MX;
            end
            S_MOX: begin
                if (mul_done) begin
                    state_next = S_MOY;
                end
            end
            S_MOY: begin
                if (mul_done) begin
                    state_next = S_MX;
                end
            end
            S_MX: begin
                if (mul_done) begin
                    state_next = S_MY;
                end
            end
            S_MY: begin
                if (mul_done) begin
                    state_next = held_ge_min ? S_NQ : S_OUT;
                end
            end
            S_NQ: begin
                if (mul_done) begin
                    state_next = S_S2;
                end
            end
            S_S2: begin
                if (mul_done) begin
                    if (var_next != '0) begin
                        state_next = S_NX;
                    end else if (!ch_reg) begin
                        state_next = S_NQ;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_NX: begin
                if (mul_done) begin
                    state_next = S_D2;
                end
            end
            S_D2: begin
                if (mul_done) begin
                    state_next = S_T2;
                end
            end
            S_T2: begin
                if (mul_done) begin
                    state_next = S_TV;
                end
            end
            S_TV: begin
                if (mul_done) begin
                    if (lhs_reg > mul_res || !ch_reg) begin
                        state_next = (lhs_reg > mul_res) ? S_OUT : S_NQ;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg    <= WLEN_RESET;
            in_thr_reg  <= THR_RESET;
            out_thr_reg <= THR_RESET;
            slot_reg    <= '0;
            held_reg    <= '0;
            in_sum_reg  <= '0;
            out_sum_reg <= '0;
            in_sq_reg   <= '0;
            out_sq_reg  <= '0;
            issued_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (mul_start) begin
                issued_reg <= 1'b1;
            end else if (mul_done) begin
                issued_reg <= 1'b0;
            end
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_WLEN: begin
                        wlen_reg    <= pwdata[LEN_W-1:0];
                        slot_reg    <= '0;
                        held_reg    <= '0;
                        in_sum_reg  <= '0;
                        out_sum_reg <= '0;
                        in_sq_reg   <= '0;
                        out_sq_reg  <= '0;
                    end
                    REG_IN_THR:  in_thr_reg  <= pwdata[THR_W-1:0];
                    REG_OUT_THR: out_thr_reg <= pwdata[THR_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (state_reg == S_READ) begin
                held_reg <= full_reg ? len_eff : held_reg + LEN_W'(1);
                slot_reg <= (slot_inc >= CMP_W'(len_eff)) ? '0 : AW'(slot_inc);
            end
            if (mul_done) begin
                case (state_reg)
                    S_MOX: begin
                        in_sq_reg  <= in_sq_reg - mul_res[SQ_W-1:0];
                        in_sum_reg <= in_sum_reg - SUM_W'(ox_reg);
                    end
                    S_MOY: begin
                        out_sq_reg  <= out_sq_reg - mul_res[SQ_W-1:0];
                        out_sum_reg <= out_sum_reg - SUM_W'(oy_reg);
                    end
                    S_MX: begin
                        in_sq_reg  <= in_sq_reg + mul_res[SQ_W-1:0];
                        in_sum_reg <= in_sum_reg + SUM_W'(x_reg);
                    end
                    S_MY: begin
                        out_sq_reg  <= out_sq_reg + mul_res[SQ_W-1:0];
                        out_sum_reg <= out_sum_reg + SUM_W'(y_reg);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            x_reg        <= s_in_size;
            y_reg        <= s_out_size;
            cur_slot_reg <= slot_eff;
            full_reg     <= (held_reg >= len_eff);
            ch_reg       <= 1'b0;
            code_reg     <= EV_NONE;
        end
        if (state_reg == S_READ) begin
            ox_reg <= mem_rdata[SB-1:0];
            oy_reg <= mem_rdata[2*SB-1:SB];
        end
        if (mul_done) begin
            case (state_reg)
                S_NQ: var_reg <= mul_res[VW-1:0];
                S_S2: begin
                    var_reg <= var_next;
                    if (var_next == '0) begin
                        ch_reg <= 1'b1;
                    end
                end
                S_NX: d_reg <= (nx >= cur_sum) ? nx - cur_sum : cur_sum - nx;
                S_D2: lhs_reg <= PW'(mul_res[2*SUM_W-1:0]) << 16;
                S_T2: t2_reg <= mul_res[31:0];
                S_TV: begin
                    if (lhs_reg > mul_res) begin
                        code_reg <= ch_reg ? EV_OUT : EV_IN;
                    end
                    ch_reg <= 1'b1;
                end
                default: begin
                end
            endcase
        end
        if (state_reg == S_OUT && out_free) begin
            held_out_reg <= held_reg;
            code_out_reg <= code_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_event_code   = code_out_reg;
    assign m_samples_held = held_out_reg;

`ifndef SYNTHESIS
    a_held_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= len_eff)
        else $error("Held sample count exceeds the window length.");
    a_slot_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> (CMP_W'(cur_slot_reg) < CMP_W'(len_eff)))
        else $error("Write slot lies outside the window.");
    a_event_needs_samples: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_code != EV_NONE) |-> (32'(m_samples_held) >= 32'(MIN_SAMPLES)))
        else $error("Event reported with too few samples held.");
    a_mul_done_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (issued_reg && is_mul))
        else $error("Multiplier finished outside a multiply step.");
`endif

endmodule
`default_nettype wire

@@ tb/window_zscore_size_outlier_core_tb.sv @@
// Self-checking testbench for window_zscore_size_outlier_core: a scoreboard model
// of the two z-score windows, APB register writes, random handshake stalls.
// Depends on wzs_pkg and the core RTL only.
`default_nettype none
module window_zscore_size_outlier_core_tb;
    import wzs_pkg::*;

    localparam int unsigned DEPTH = 1024;
    localparam int unsigned MIN_HELD = 20;
    localparam int PEND_MAX = 4096;
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef struct {
        logic [23:0] in_sz;
        logic [23:0] out_sz;
    } size_pair_t;

    typedef struct {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  held;
    } verdict_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [23:0]       s_in_size = '0;
    logic [23:0]       s_out_size = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [CODE_W-1:0] m_event_code;
    logic [LEN_W-1:0]  m_samples_held;

    window_zscore_size_outlier_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_in_size(s_in_size), .s_out_size(s_out_size),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_event_code(m_event_code), .m_samples_held(m_samples_held)
    );

    always #5 aclk = ~aclk;

    size_pair_t pend_items[PEND_MAX];
    int         pend_wr = 0;
    int         pend_rd = 0;
    verdict_t   verdict_buf[PEND_MAX];
    int         vb_wr = 0;
    int         vb_rd = 0;
    size_pair_t cur_pair;
    int         errors = 0;
    int         checked = 0;
    int         flagged = 0;
    bit         calm = 1'b0;
    int         send_gap = 0;
    int         recv_stall = 0;

    logic [23:0]      hist_in[DEPTH];
    logic [23:0]      hist_out[DEPTH];
    int unsigned      wslot;
    int unsigned      held;
    logic [63:0]      sum_in, sum_out;
    logic [127:0]     sq_in, sq_out;
    logic [LEN_W-1:0] wlen;
    logic [THR_W-1:0] thr_in, thr_out;

    function automatic void clear_windows();
        wslot = 0;
        held = 0;
        sum_in = '0;
        sum_out = '0;
        sq_in = '0;
        sq_out = '0;
    endfunction

    function automatic bit is_unusual(logic [23:0] x, logic [63:0] s, logic [127:0] q,
                                      int unsigned n, logic [THR_W-1:0] t);
        logic [127:0] nw, xw, sw, tw, nx, d, spread, lhs, rhs;
        nw = n;
        xw = x;
        sw = s;
        tw = t;
        nx = nw * xw;
        d = (nx >= sw) ? nx - sw : sw - nx;
        spread = nw * q - sw * sw;
        if (spread == 0)
            return 1'b0;
        lhs = (d * d) << 16;
        rhs = tw * tw * spread;
        return lhs > rhs;
    endfunction

    function automatic verdict_t score_item(size_pair_t p);
        verdict_t v;
        int unsigned len, slot;
        logic [127:0] ox, oy, nx, ny;
        len = (wlen == 0) ? 1 : ((wlen > DEPTH) ? DEPTH : wlen);
        slot = (wslot >= len) ? 0 : wslot;
        if (held >= len) begin
            ox = hist_in[slot];
            oy = hist_out[slot];
            sum_in -= ox[63:0];
            sum_out -= oy[63:0];
            sq_in -= ox * ox;
            sq_out -= oy * oy;
            held = len;
        end else begin
            held++;
        end
        hist_in[slot] = p.in_sz;
        hist_out[slot] = p.out_sz;
        nx = p.in_sz;
        ny = p.out_sz;
        sum_in += nx[63:0];
        sum_out += ny[63:0];
        sq_in += nx * nx;
        sq_out += ny * ny;
        slot++;
        wslot = (slot >= len) ? 0 : slot;
        v.code = EV_NONE;
        if (held >= MIN_HELD) begin
            if (is_unusual(p.in_sz, sum_in, sq_in, held, thr_in))
                v.code = EV_IN;
            else if (is_unusual(p.out_sz, sum_out, sq_out, held, thr_out))
                v.code = EV_OUT;
        end
        v.held = held[LEN_W-1:0];
        return v;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                verdict_buf[vb_wr % PEND_MAX] = score_item(cur_pair);
                vb_wr++;
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(1, 18) - 1;
                s_valid <= 1'b0;
            end else if (pend_rd != pend_wr) begin
                cur_pair = pend_items[pend_rd % PEND_MAX];
                pend_rd++;
                s_valid <= 1'b1;
                s_in_size <= cur_pair.in_sz;
                s_out_size <= cur_pair.out_sz;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (vb_rd == vb_wr) begin
                    $display("%0t: unexpected transaction, actual code %0d held %0d",
                             $time, m_event_code, m_samples_held);
                    errors++;
                end else begin
                    want = verdict_buf[vb_rd % PEND_MAX];
                    vb_rd++;
                    checked++;
                    if (want.code != EV_NONE)
                        flagged++;
                    if (m_event_code !== want.code) begin
                        $display("%0t: event_code expected %0d actual %0d",
                                 $time, want.code, m_event_code);
                        errors++;
                    end
                    if (m_samples_held !== want.held) begin
                        $display("%0t: samples_held expected %0d actual %0d",
                                 $time, want.held, m_samples_held);
                        errors++;
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                recv_stall <= $urandom_range(1, 18) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic reg_write(input logic [1:0] index, input logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_WLEN: begin
                wlen = data[LEN_W-1:0];
                clear_windows();
            end
            REG_IN_THR:  thr_in = data[THR_W-1:0];
            REG_OUT_THR: thr_out = data[THR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic add_pair(input logic [23:0] a, input logic [23:0] b);
        size_pair_t p;
        p.in_sz = a;
        p.out_sz = b;
        pend_items[pend_wr % PEND_MAX] = p;
        pend_wr++;
    endtask

    function automatic logic [23:0] pick_size(logic [23:0] base);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return 24'($urandom());
        if (r < 12)
            return (r < 9) ? 24'hFFFFFF : 24'h0;
        return base ^ 24'($urandom_range(0, 63));
    endfunction

    task automatic drain();
        while (pend_rd != pend_wr || s_valid || vb_rd != vb_wr)
            @(posedge aclk);
    endtask

    task automatic run_phase(input int count);
        logic [23:0] base_in, base_out;
        base_in = 24'($urandom());
        base_out = 24'($urandom());
        if ($urandom_range(0, 1))
            base_in = 24'($urandom_range(0, 4095));
        repeat (count)
            add_pair(pick_size(base_in), pick_size(base_out));
        drain();
    endtask

    task automatic configure(input logic [31:0] len, input logic [15:0] ti,
                             input logic [15:0] to);
        reg_write(REG_WLEN, len);
        reg_write(REG_IN_THR, {16'($urandom_range(0, 65535)), ti});
        reg_write(REG_OUT_THR, {16'h0, to});
    endtask

    initial begin
        wlen = WLEN_RESET;
        thr_in = THR_RESET;
        thr_out = THR_RESET;
        clear_windows();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        repeat (20)
            add_pair(24'd5, 24'd5);
        add_pair(24'hFFFFFF, 24'd5);
        add_pair(24'd5, 24'hFFFFFF);
        add_pair(24'h0, 24'h0);
        add_pair(24'hAAAAAA, 24'h555555);
        drain();

        configure(32'd20, 16'd768, 16'd768);
        run_phase(200);
        configure(32'hFFFF_F800, 16'd300, 16'd300);
        run_phase(40);
        configure(32'd1, 16'd0, 16'd0);
        run_phase(40);
        configure(32'd19, 16'd0, 16'd0);
        run_phase(60);
        configure(32'd2047, 16'hFFFF, 16'd0);
        run_phase(150);
        configure(32'd21, 16'd0, 16'hFFFF);
        run_phase(150);
        repeat (3) begin
            configure($urandom_range(20, 100), 16'($urandom_range(0, 1200)),
                      16'($urandom_range(0, 1200)));
            reg_write(REG_SPARE, $urandom());
            run_phase(100);
        end
        configure(32'd300, 16'd256, 16'd256);
        run_phase(450);
        configure(32'd32, 16'($urandom_range(0, 1024)), 16'($urandom_range(0, 1024)));
        calm = 1'b1;
        run_phase(200);

        repeat (50) @(posedge aclk);
        $display("Checked %0d result transactions, %0d of them flagged as unusual,", checked,
                 flagged);
        $display("over window lengths from 0 to 2047 and thresholds from 0 to 65535.");
        if (errors == 0 && vb_rd == vb_wr) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("Timeout with %0d results outstanding.", vb_wr - vb_rd);
        $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
